// ----- sv/rse_pkg.sv -----
package rse_pkg;

    localparam logic [6:0] OPC_OP     = 7'b0110011;
    localparam logic [6:0] OPC_IMM    = 7'b0010011;
    localparam logic [6:0] OPC_LOAD   = 7'b0000011;
    localparam logic [6:0] OPC_STORE  = 7'b0100011;
    localparam logic [6:0] OPC_BRANCH = 7'b1100011;
    localparam logic [6:0] OPC_LUI    = 7'b0110111;
    localparam logic [6:0] OPC_JAL    = 7'b1101111;

    localparam logic [2:0] F3_ADD  = 3'd0;
    localparam logic [2:0] F3_SLL  = 3'd1;
    localparam logic [2:0] F3_SLT  = 3'd2;
    localparam logic [2:0] F3_XOR  = 3'd4;
    localparam logic [2:0] F3_OR   = 3'd6;
    localparam logic [2:0] F3_AND  = 3'd7;
    localparam logic [2:0] F3_WORD = 3'd2;
    localparam logic [2:0] F3_BEQ  = 3'd0;
    localparam logic [2:0] F3_BNE  = 3'd1;

    localparam logic [6:0] F7_BASE = 7'b0000000;
    localparam logic [6:0] F7_ALT  = 7'b0100000;

    localparam logic [4:0] REG_ZERO = 5'h00;
    localparam logic [4:0] SHAMT_MASK = 5'h1F;

    localparam logic [1:0] FAULT_NONE  = 2'd0;
    localparam logic [1:0] FAULT_UNDEF = 2'd1;
    localparam logic [1:0] FAULT_RANGE = 2'd2;

    typedef struct packed {
        logic [31:0] instruction;
        logic [31:0] pc;
    } t_in_item;

    typedef struct packed {
        logic [31:0] next_pc;
        logic        reg_written;
        logic [4:0]  dest_register;
        logic [31:0] written_value;
        logic        mem_written;
        logic [1:0]  fault;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic commit_exec;
        logic commit_load;
        logic clr_step;
    } t_cmd;

    typedef struct packed {
        logic is_load;
        logic clr_last;
    } t_sts;

endpackage

// ----- sv/rv32i_subset_executor.sv -----
// channel | direction | handshake                 | payload
// in      | input     | i_in_valid / o_in_stall   | i_in  (instruction, pc)
// out     | output    | o_out_valid / i_out_stall | o_out (next_pc, write, fault)
//
// After accept the input stays stalled through execute (lw: execute and load) until the result is committed.
// The result beat is registered when execute commits (lw: when the load state commits), after the
// registered reads of the register file and the data memory RAMs.
// After reset the data memory is swept to zero, word by word up to DATA_WORDS-1, with o_in_stall high.
// A result beat waits in the output register; a stalled output holds the next
// instruction in execute (lw: in the load state) until the register frees.
module rv32i_subset_executor
    import rse_pkg::*;
#(
    parameter int DATA_WORDS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_item  i_in,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out
);

    t_cmd cmd;
    t_sts sts;

    rse_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid)
    );

    rse_dp #(.DATA_WORDS(DATA_WORDS)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_in    (i_in),
        .o_sts   (sts),
        .o_out   (o_out)
    );

    a_stall_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall
    ) else $error("input not stalled after accepted beat");

    a_fault_no_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.fault != FAULT_NONE) |->
            (!o_out.reg_written && !o_out.mem_written && o_out.written_value == 32'd0)
    ) else $error("faulting result carries a write");

    a_no_x0_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.reg_written) |-> (o_out.dest_register != REG_ZERO)
    ) else $error("write reported to x0");

    a_single_write: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out.reg_written && o_out.mem_written)
    ) else $error("result reports both register and memory write");

endmodule

// ----- sv/rse_ram.sv -----
module rse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- sv/rse_ctrl.sv -----
module rse_ctrl
    import rse_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_stall,
    output logic o_out_valid
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_LOAD
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        n_out_valid = r_out_valid && i_out_stall;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (i_sts.is_load) begin
                    n_state = ST_LOAD;
                end else if (out_free) begin
                    o_cmd.commit_exec = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_LOAD: begin
                if (out_free) begin
                    o_cmd.commit_load = 1'b1;
                    n_out_valid       = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

// ----- sv/rse_dp.sv -----
module rse_dp
    import rse_pkg::*;
#(
    parameter int DATA_WORDS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cmd      i_cmd,
    input  t_in_item  i_in,
    output t_sts      o_sts,
    output t_out_item o_out
);

    localparam int AW = $clog2(DATA_WORDS);
    localparam logic [31:0] MEM_LIMIT = 32'(DATA_WORDS);
    localparam logic [AW-1:0] LAST_ADDR = AW'(DATA_WORDS - 1);

    logic [31:0]   r_ins;
    logic [31:0]   r_pc;
    logic [31:0]   r_rf_valid;
    logic [AW-1:0] r_clr_addr;
    t_out_item     r_out;

    logic [4:0]  rs1_idx;
    logic [4:0]  rs2_idx;
    logic [4:0]  rd_raddr1;
    logic [4:0]  rd_raddr2;
    logic [31:0] rf_rdata1;
    logic [31:0] rf_rdata2;
    logic [31:0] a;
    logic [31:0] b;

    logic [6:0]  opc;
    logic [4:0]  rd;
    logic [2:0]  f3;
    logic [6:0]  f7;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_b;
    logic [31:0] imm_j;
    logic [31:0] op2;
    logic [31:0] addsum;
    logic [31:0] pc4;
    logic [31:0] target;
    logic        in_range;

    logic [1:0]  fault;
    logic        wr;
    logic        mw;
    logic        ld;
    logic [31:0] val;
    logic [31:0] next_pc;

    logic          rf_we;
    logic [31:0]   rf_wdata;
    logic          dm_we;
    logic [AW-1:0] dm_waddr;
    logic [31:0]   dm_wdata;
    logic [31:0]   dm_rdata;

    assign rs1_idx   = r_ins[19:15];
    assign rs2_idx   = r_ins[24:20];
    assign rd_raddr1 = i_cmd.capture ? i_in.instruction[19:15] : rs1_idx;
    assign rd_raddr2 = i_cmd.capture ? i_in.instruction[24:20] : rs2_idx;

    assign a = r_rf_valid[rs1_idx] ? rf_rdata1 : 32'd0;
    assign b = r_rf_valid[rs2_idx] ? rf_rdata2 : 32'd0;

    assign opc = r_ins[6:0];
    assign rd  = r_ins[11:7];
    assign f3  = r_ins[14:12];
    assign f7  = r_ins[31:25];

    assign imm_i = {{20{r_ins[31]}}, r_ins[31:20]};
    assign imm_s = {{20{r_ins[31]}}, r_ins[31:25], r_ins[11:7]};
    assign imm_b = {{19{r_ins[31]}}, r_ins[31], r_ins[7], r_ins[30:25], r_ins[11:8], 1'b0};
    assign imm_j = {{11{r_ins[31]}}, r_ins[31], r_ins[19:12], r_ins[20], r_ins[30:21], 1'b0};

    assign op2      = (opc == OPC_OP) ? b : ((opc == OPC_STORE) ? imm_s : imm_i);
    assign addsum   = a + op2;
    assign pc4      = r_pc + 32'd4;
    assign target   = r_pc + ((opc == OPC_JAL) ? imm_j : imm_b);
    assign in_range = (addsum < MEM_LIMIT);

    always_comb begin
        fault   = FAULT_NONE;
        wr      = 1'b0;
        mw      = 1'b0;
        ld      = 1'b0;
        val     = 32'd0;
        next_pc = pc4;
        case (opc)
            OPC_OP: begin
                wr = 1'b1;
                if (f3 == F3_ADD && f7 == F7_BASE) begin
                    val = addsum;
                end else if (f3 == F3_ADD && f7 == F7_ALT) begin
                    val = a - b;
                end else if (f3 == F3_SLL && f7 == F7_BASE) begin
                    val = a << (b[4:0] & SHAMT_MASK);
                end else if (f3 == F3_AND && f7 == F7_BASE) begin
                    val = a & b;
                end else if (f3 == F3_OR && f7 == F7_BASE) begin
                    val = a | b;
                end else begin
                    wr    = 1'b0;
                    fault = FAULT_UNDEF;
                end
            end
            OPC_IMM: begin
                wr = 1'b1;
                if (f3 == F3_ADD) begin
                    val = addsum;
                end else if (f3 == F3_SLT) begin
                    val = {31'd0, ($signed(a) < $signed(imm_i))};
                end else if (f3 == F3_XOR) begin
                    val = a ^ imm_i;
                end else begin
                    wr    = 1'b0;
                    fault = FAULT_UNDEF;
                end
            end
            OPC_LOAD: begin
                if (f3 != F3_WORD) begin
                    fault = FAULT_UNDEF;
                end else if (!in_range) begin
                    fault = FAULT_RANGE;
                end else begin
                    ld = 1'b1;
                end
            end
            OPC_STORE: begin
                if (f3 != F3_WORD) begin
                    fault = FAULT_UNDEF;
                end else if (!in_range) begin
                    fault = FAULT_RANGE;
                end else begin
                    mw = 1'b1;
                end
            end
            OPC_BRANCH: begin
                if (f3 == F3_BEQ) begin
                    if (a == b) begin
                        next_pc = target;
                    end
                end else if (f3 == F3_BNE) begin
                    if (a != b) begin
                        next_pc = target;
                    end
                end else begin
                    fault = FAULT_UNDEF;
                end
            end
            OPC_JAL: begin
                wr      = 1'b1;
                val     = pc4;
                next_pc = target;
            end
            OPC_LUI: begin
                wr  = 1'b1;
                val = {r_ins[31:12], 12'd0};
            end
            default: begin
                fault = FAULT_UNDEF;
            end
        endcase
    end

    assign rf_we    = (rd != REG_ZERO) &&
                      ((i_cmd.commit_exec && wr) || i_cmd.commit_load);
    assign rf_wdata = i_cmd.commit_load ? dm_rdata : val;

    assign dm_we    = i_cmd.clr_step || (i_cmd.commit_exec && mw);
    assign dm_waddr = i_cmd.clr_step ? r_clr_addr : addsum[AW-1:0];
    assign dm_wdata = i_cmd.clr_step ? 32'd0 : b;

    rse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rd),
        .i_wdata (rf_wdata),
        .i_raddr (rd_raddr1),
        .o_rdata (rf_rdata1)
    );

    rse_ram #(.WIDTH(32), .DEPTH(32)) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rd),
        .i_wdata (rf_wdata),
        .i_raddr (rd_raddr2),
        .o_rdata (rf_rdata2)
    );

    rse_ram #(.WIDTH(32), .DEPTH(DATA_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_raddr (addsum[AW-1:0]),
        .o_rdata (dm_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_valid <= '0;
            r_clr_addr <= '0;
        end else begin
            if (rf_we) begin
                r_rf_valid[rd] <= 1'b1;
            end
            if (i_cmd.clr_step) begin
                r_clr_addr <= r_clr_addr + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ins <= i_in.instruction;
            r_pc  <= i_in.pc;
        end
        if (i_cmd.commit_exec) begin
            r_out.next_pc       <= next_pc;
            r_out.reg_written   <= rf_we;
            r_out.dest_register <= rf_we ? rd : REG_ZERO;
            r_out.written_value <= rf_we ? val : 32'd0;
            r_out.mem_written   <= mw;
            r_out.fault         <= fault;
        end else if (i_cmd.commit_load) begin
            r_out.next_pc       <= pc4;
            r_out.reg_written   <= rf_we;
            r_out.dest_register <= rf_we ? rd : REG_ZERO;
            r_out.written_value <= rf_we ? dm_rdata : 32'd0;
            r_out.mem_written   <= 1'b0;
            r_out.fault         <= FAULT_NONE;
        end
    end

    assign o_sts.is_load  = ld;
    assign o_sts.clr_last = (r_clr_addr == LAST_ADDR);
    assign o_out          = r_out;

endmodule
